FILE: src/seed_segment_crossing_checker_assert.svh
// Assertion macros used by the checker's back end (ssc_back).
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SEED_SEGMENT_CROSSING_CHECKER_ASSERT_SVH
`define SEED_SEGMENT_CROSSING_CHECKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ssc_pkg.sv
// Shared types, codes and helpers of the seed segment crossing checker.
// No dependencies.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int IN_COORD_W = 16;
  localparam int KIND_W     = 3;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [6:0] LEGAL_MAX = 7'd127;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 3'd0,
    KIND_H    = 3'd1,
    KIND_V    = 3'd2,
    KIND_DP   = 3'd3,
    KIND_DN   = 3'd4
  } kind_t;

  // control part of one queued item
  typedef struct packed {
    logic [1:0] cmd;
    logic       hard;
    kind_t      kind;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  function automatic logic perpendicular(kind_t p, kind_t q);
    return (p == KIND_H  && q == KIND_V)  || (p == KIND_V  && q == KIND_H) ||
           (p == KIND_DP && q == KIND_DN) || (p == KIND_DN && q == KIND_DP);
  endfunction

endpackage

FILE: src/ssc_front.sv
// Front end: accepts items, trims or zero-extends coordinates to the grid width and classifies
// the segment direction. Depends on ssc_pkg; feeds ssc_fifo.
`timescale 1ns / 1ps

module ssc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_cmd,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0]   in_start_x,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0]   in_start_y,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0]   in_end_x,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0]   in_end_y,
  input  logic                                    in_hard_in,
  input  logic                                    q_full,
  output logic                                    q_push,
  output logic [ssc_pkg::CTL_W+4*COORD_BITS-1:0]  q_wdata
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;

  logic [ssc_pkg::IN_COORD_W-1:0] raw [4];
  logic signed [CW-1:0]           crd [4];
  logic signed [DW-1:0]           dx, dy;
  ssc_pkg::kind_t                 kind;
  ssc_pkg::ctl_t                  ctl;

  assign raw[0] = in_start_x;
  assign raw[1] = in_start_y;
  assign raw[2] = in_end_x;
  assign raw[3] = in_end_y;

  generate
    if (CW <= ssc_pkg::IN_COORD_W) begin : g_narrow
      for (genvar k = 0; k < 4; k++) begin : g_crd
        assign crd[k] = $signed(raw[k][CW-1:0]);
      end
    end else begin : g_wide
      // port value is taken as an unsigned pattern, upper grid bits zero
      for (genvar k = 0; k < 4; k++) begin : g_crd
        assign crd[k] = $signed({{(CW-ssc_pkg::IN_COORD_W){1'b0}}, raw[k]});
      end
    end
  endgenerate

  assign dx = DW'(crd[2]) - DW'(crd[0]);
  assign dy = DW'(crd[3]) - DW'(crd[1]);

  // a single point counts as horizontal
  always_comb begin
    if (dy == '0)       kind = ssc_pkg::KIND_H;
    else if (dx == '0)  kind = ssc_pkg::KIND_V;
    else if (dx == dy)  kind = ssc_pkg::KIND_DP;
    else if (dx == -dy) kind = ssc_pkg::KIND_DN;
    else                kind = ssc_pkg::KIND_NONE;
  end

  always_comb begin
    ctl.cmd  = in_cmd;
    ctl.hard = in_hard_in;
    ctl.kind = kind;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {ctl, crd[0], crd[1], crd[2], crd[3]};

endmodule

FILE: src/ssc_fifo.sv
// Two-entry item queue between the front end and the back end.
// No dependencies.
`timescale 1ns / 1ps

module ssc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: src/ssc_back.sv
// Back end: segment table memory, clear/append handling and the pipelined
// crossing walk with the output register. Depends on ssc_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "seed_segment_crossing_checker_assert.svh"

module ssc_back #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  input  logic [ssc_pkg::CTL_W+4*COORD_BITS-1:0]  q_rdata,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_violates,
  output logic [6:0]                              out_legal_crossings,
  output logic                                    out_status
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int OW   = PW + 1;
  localparam int EW   = 4 * CW + 1 + ssc_pkg::KIND_W;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } st_t;

  st_t st_r, st_nxt;

  ssc_pkg::ctl_t        q_ctl;
  logic signed [CW-1:0] q_ax, q_ay, q_bx, q_by;

  assign q_ctl = ssc_pkg::ctl_t'(q_rdata[ssc_pkg::CTL_W+4*CW-1 -: ssc_pkg::CTL_W]);
  assign q_ax  = $signed(q_rdata[4*CW-1 -: CW]);
  assign q_ay  = $signed(q_rdata[3*CW-1 -: CW]);
  assign q_bx  = $signed(q_rdata[2*CW-1 -: CW]);
  assign q_by  = $signed(q_rdata[CW-1:0]);

  // control
  logic [CNTW-1:0] cnt_r, idx_r;
  logic            viol_r;
  logic [6:0]      legal_r;
  logic            v1_r, v2_r, v3_r;
  logic            out_valid_r, out_viol_r, out_status_r;
  logic [6:0]      out_legal_r;
  logic            out_free, out_load, issue, walk_end, tbl_full, app_we;
  logic            hit_viol, hit_legal;
  logic            o_viol, o_status;
  logic [6:0]      o_legal;

  // candidate
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [CW-1:0] blox_r, bhix_r, bloy_r, bhiy_r;
  logic signed [DW-1:0] abx_r, aby_r;
  ssc_pkg::kind_t       ck_r;

  // memory
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_r;

  assign out_free = !out_valid_r || !out_stall;
  assign tbl_full = (cnt_r == CNTW'(MAX_SEGMENTS));
  assign q_pop    = (st_r == S_IDLE) && !q_empty && out_free;
  assign app_we   = q_pop && (q_ctl.cmd == ssc_pkg::CMD_APPEND) && !tbl_full;
  assign issue    = (st_r == S_WALK) && (idx_r < cnt_r) && !viol_r;
  assign walk_end = (st_r == S_WALK) && !issue && !v1_r && !v2_r && !v3_r;
  assign out_load = (q_pop && (q_ctl.cmd != ssc_pkg::CMD_CHECK)) ||
                    ((st_r == S_DONE) && out_free);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (q_pop && (q_ctl.cmd == ssc_pkg::CMD_CHECK)) st_nxt = S_WALK;
      S_WALK:  if (walk_end) st_nxt = S_DONE;
      S_DONE:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (st_r == S_DONE) begin
      o_viol   = viol_r;
      o_legal  = legal_r;
      o_status = ssc_pkg::ST_OK;
    end else begin
      o_viol   = 1'b0;
      o_legal  = 7'd0;
      o_status = ((q_ctl.cmd == ssc_pkg::CMD_APPEND) && tbl_full) ?
                 ssc_pkg::ST_FULL : ssc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      viol_r      <= 1'b0;
      legal_r     <= 7'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (q_pop && (q_ctl.cmd == ssc_pkg::CMD_CLEAR)) cnt_r <= '0;
      else if (app_we)                                cnt_r <= cnt_r + CNTW'(1);
      if (q_pop && (q_ctl.cmd == ssc_pkg::CMD_CHECK)) begin
        idx_r   <= '0;
        viol_r  <= 1'b0;
        legal_r <= 7'd0;
      end else begin
        if (issue)    idx_r  <= idx_r + CNTW'(1);
        if (hit_viol) viol_r <= 1'b1;
        if (hit_legal && (legal_r != ssc_pkg::LEGAL_MAX)) legal_r <= legal_r + 7'd1;
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_viol_r   <= o_viol;
      out_legal_r  <= o_legal;
      out_status_r <= o_status;
    end
    // latch the candidate and its bounding box
    if (q_pop && (q_ctl.cmd == ssc_pkg::CMD_CHECK)) begin
      ax_r   <= q_ax;
      ay_r   <= q_ay;
      bx_r   <= q_bx;
      by_r   <= q_by;
      blox_r <= (q_ax < q_bx) ? q_ax : q_bx;
      bhix_r <= (q_ax < q_bx) ? q_bx : q_ax;
      bloy_r <= (q_ay < q_by) ? q_ay : q_by;
      bhiy_r <= (q_ay < q_by) ? q_by : q_ay;
      abx_r  <= DW'(q_bx) - DW'(q_ax);
      aby_r  <= DW'(q_by) - DW'(q_ay);
      ck_r   <= q_ctl.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (app_we) mem[cnt_r[IW-1:0]] <= {q_ctl.hard, q_ctl.kind, q_ax, q_ay, q_bx, q_by};
    if (issue)  rd_r <= mem[idx_r[IW-1:0]];
  end

  // stage 1: differences, box tests and endpoint compares
  logic signed [CW-1:0] cx, cy, dx, dy, slox, shix, sloy, shiy;
  ssc_pkg::kind_t       skind;
  logic                 shard;

  assign shard = rd_r[EW-1];
  assign skind = ssc_pkg::kind_t'(rd_r[EW-2 -: ssc_pkg::KIND_W]);
  assign cx    = $signed(rd_r[4*CW-1 -: CW]);
  assign cy    = $signed(rd_r[3*CW-1 -: CW]);
  assign dx    = $signed(rd_r[2*CW-1 -: CW]);
  assign dy    = $signed(rd_r[CW-1:0]);
  assign slox  = (cx < dx) ? cx : dx;
  assign shix  = (cx < dx) ? dx : cx;
  assign sloy  = (cy < dy) ? cy : dy;
  assign shiy  = (cy < dy) ? dy : cy;

  logic signed [DW-1:0] acx_r, acy_r, adx_r, ady_r, cdx_r, cdy_r;
  logic signed [DW-1:0] cax_r, cay_r, cbx_r, cby_r;
  logic [3:0]           w2_r, w3_r;
  logic                 same2_r, share2_r, hard2_r, perp2_r;

  logic eq_ac, eq_ad, eq_bc, eq_bd;
  assign eq_ac = (ax_r == cx) && (ay_r == cy);
  assign eq_ad = (ax_r == dx) && (ay_r == dy);
  assign eq_bc = (bx_r == cx) && (by_r == cy);
  assign eq_bd = (bx_r == dx) && (by_r == dy);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      acx_r <= DW'(cx) - DW'(ax_r);
      acy_r <= DW'(cy) - DW'(ay_r);
      adx_r <= DW'(dx) - DW'(ax_r);
      ady_r <= DW'(dy) - DW'(ay_r);
      cdx_r <= DW'(dx) - DW'(cx);
      cdy_r <= DW'(dy) - DW'(cy);
      cax_r <= DW'(ax_r) - DW'(cx);
      cay_r <= DW'(ay_r) - DW'(cy);
      cbx_r <= DW'(bx_r) - DW'(cx);
      cby_r <= DW'(by_r) - DW'(cy);
      w2_r[0] <= (blox_r <= cx) && (cx <= bhix_r) && (bloy_r <= cy) && (cy <= bhiy_r);
      w2_r[1] <= (blox_r <= dx) && (dx <= bhix_r) && (bloy_r <= dy) && (dy <= bhiy_r);
      w2_r[2] <= (slox <= ax_r) && (ax_r <= shix) && (sloy <= ay_r) && (ay_r <= shiy);
      w2_r[3] <= (slox <= bx_r) && (bx_r <= shix) && (sloy <= by_r) && (by_r <= shiy);
      same2_r  <= (eq_ac && eq_bd) || (eq_ad && eq_bc);
      share2_r <= eq_ac || eq_ad || eq_bc || eq_bd;
      hard2_r  <= shard;
      perp2_r  <= ssc_pkg::perpendicular(ck_r, skind);
    end
  end

  // stage 2: orientation products
  logic signed [PW-1:0] p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r;
  logic                 same3_r, share3_r, hard3_r, perp3_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      p1a_r    <= abx_r * acy_r;
      p1b_r    <= aby_r * acx_r;
      p2a_r    <= abx_r * ady_r;
      p2b_r    <= aby_r * adx_r;
      p3a_r    <= cdx_r * cay_r;
      p3b_r    <= cdy_r * cax_r;
      p4a_r    <= cdx_r * cby_r;
      p4b_r    <= cdy_r * cbx_r;
      w3_r     <= w2_r;
      same3_r  <= same2_r;
      share3_r <= share2_r;
      hard3_r  <= hard2_r;
      perp3_r  <= perp2_r;
    end
  end

  // stage 3: orientation signs, crossing test and rule order
  logic signed [OW-1:0] o1, o2, o3, o4;
  logic [1:0]           s1, s2, s3, s4;
  logic                 crosses;

  assign o1 = OW'(p1a_r) - OW'(p1b_r);
  assign o2 = OW'(p2a_r) - OW'(p2b_r);
  assign o3 = OW'(p3a_r) - OW'(p3b_r);
  assign o4 = OW'(p4a_r) - OW'(p4b_r);
  // sign code: {negative, zero}
  assign s1 = {o1[OW-1], o1 == '0};
  assign s2 = {o2[OW-1], o2 == '0};
  assign s3 = {o3[OW-1], o3 == '0};
  assign s4 = {o4[OW-1], o4 == '0};

  assign crosses = ((s1 != s2) && (s3 != s4)) ||
                   (s1[0] && w3_r[0]) || (s2[0] && w3_r[1]) ||
                   (s3[0] && w3_r[2]) || (s4[0] && w3_r[3]);

  // classify each crossing in rule order; drop any segment still in flight once the walk has stopped
  always_comb begin
    hit_viol  = 1'b0;
    hit_legal = 1'b0;
    if (v3_r && !viol_r && crosses) begin
      if (same3_r || hard3_r) hit_viol = 1'b1;
      else if (share3_r)      hit_viol = 1'b0;
      else if (perp3_r)       hit_legal = 1'b1;
      else                    hit_viol = 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_violates        = out_viol_r;
  assign out_legal_crossings = out_legal_r;
  assign out_status          = out_status_r;

  `SSC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNTW'(MAX_SEGMENTS), "segment count above table depth")
  `SSC_ASSERT_NXT(a_viol_sticky, (st_r == S_WALK) && viol_r, viol_r, "violation flag dropped mid-walk")
  `SSC_ASSERT_IMP(a_legal_le_idx, (st_r == S_WALK) || (st_r == S_DONE), legal_r <= idx_r, "more crossings than segments read")
  `SSC_ASSERT_IMP(a_no_out_walk, st_r == S_WALK, !out_load, "result loaded during a walk")

endmodule

FILE: src/seed_segment_crossing_checker.sv
// Seed segment crossing checker: front end, two-entry queue, back end.
// Clear, append and unused commands are taken one per cycle while the output is not stalled;
// a check holds the back end while the walk reads the stored segments (up to MAX_SEGMENTS)
// one per cycle through one memory read port; the walk stops issuing reads once a violation
// is found.
// Reset (synchronous, rst_n low) empties table count, queue and output; memory is kept.
`timescale 1ns / 1ps

module seed_segment_crossing_checker #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_cmd,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0] in_start_x,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0] in_start_y,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0] in_end_x,
  input  logic signed [ssc_pkg::IN_COORD_W-1:0] in_end_y,
  input  logic                                  in_hard_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_violates,
  output logic [6:0]                            out_legal_crossings,
  output logic                                  out_status
);

  localparam int QW = ssc_pkg::CTL_W + 4 * COORD_BITS;

  logic          q_full, q_empty, q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  ssc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_hard_in (in_hard_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  ssc_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ssc_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_violates        (out_violates),
    .out_legal_crossings (out_legal_crossings),
    .out_status          (out_status)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for seed_segment_crossing_checker: table clear, append and crossing checks.
// Depends on ssc_pkg for command, status and segment-kind codes; a scoreboard class predicts
// every result, the send task and a stall process drive the valid/stall channels.
`timescale 1ns / 1ps

typedef struct packed {
  logic       violates;
  logic [6:0] legal;
  logic       status;
} crossing_result_t;

class crossing_scoreboard;
  localparam int DEPTH = 64;

  longint           tab_ax[DEPTH];
  longint           tab_ay[DEPTH];
  longint           tab_bx[DEPTH];
  longint           tab_by[DEPTH];
  bit               tab_hard[DEPTH];
  int               tab_count;
  crossing_result_t pending[$];
  int               errors;

  function new();
    tab_count = 0;
    errors    = 0;
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function int orient_sign(longint ax, longint ay, longint bx, longint by,
                           longint cx, longint cy);
    longint v;
    v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function bit in_box(longint px, longint py, longint ax, longint ay,
                      longint bx, longint by);
    longint lx, hx, ly, hy;
    lx = (ax < bx) ? ax : bx;
    hx = (ax < bx) ? bx : ax;
    ly = (ay < by) ? ay : by;
    hy = (ay < by) ? by : ay;
    return (lx <= px) && (px <= hx) && (ly <= py) && (py <= hy);
  endfunction

  function ssc_pkg::kind_t seg_kind(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, adx, ady;
    dx  = bx - ax;
    dy  = by - ay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (dy == 0) return ssc_pkg::KIND_H;
    if (dx == 0) return ssc_pkg::KIND_V;
    if (adx == ady) return (dx == dy) ? ssc_pkg::KIND_DP : ssc_pkg::KIND_DN;
    return ssc_pkg::KIND_NONE;
  endfunction

  function bit right_angle(ssc_pkg::kind_t p, ssc_pkg::kind_t q);
    return (p == ssc_pkg::KIND_H  && q == ssc_pkg::KIND_V) ||
           (p == ssc_pkg::KIND_V  && q == ssc_pkg::KIND_H) ||
           (p == ssc_pkg::KIND_DP && q == ssc_pkg::KIND_DN) ||
           (p == ssc_pkg::KIND_DN && q == ssc_pkg::KIND_DP);
  endfunction

  function bit segs_cross(longint ax, longint ay, longint bx, longint by,
                          longint cx, longint cy, longint dx, longint dy);
    int o1, o2, o3, o4;
    o1 = orient_sign(ax, ay, bx, by, cx, cy);
    o2 = orient_sign(ax, ay, bx, by, dx, dy);
    o3 = orient_sign(cx, cy, dx, dy, ax, ay);
    o4 = orient_sign(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == 0 && in_box(cx, cy, ax, ay, bx, by)) return 1'b1;
    if (o2 == 0 && in_box(dx, dy, ax, ay, bx, by)) return 1'b1;
    if (o3 == 0 && in_box(ax, ay, cx, cy, dx, dy)) return 1'b1;
    if (o4 == 0 && in_box(bx, by, cx, cy, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // work out the result of one accepted item and queue it
  function void note_item(logic [1:0] cmd, logic signed [15:0] sx, logic signed [15:0] sy,
                          logic signed [15:0] ex, logic signed [15:0] ey, logic hard);
    longint           ax, ay, bx, by, cx, cy, dx, dy;
    crossing_result_t r;
    ssc_pkg::kind_t   ck;
    bit               stop, same, shared;
    ax = sx;
    ay = sy;
    bx = ex;
    by = ey;
    r  = '0;
    case (cmd)
      ssc_pkg::CMD_CLEAR: tab_count = 0;
      ssc_pkg::CMD_APPEND: begin
        if (tab_count >= DEPTH) begin
          r.status = ssc_pkg::ST_FULL;
        end else begin
          tab_ax[tab_count]   = ax;
          tab_ay[tab_count]   = ay;
          tab_bx[tab_count]   = bx;
          tab_by[tab_count]   = by;
          tab_hard[tab_count] = hard;
          tab_count++;
        end
      end
      ssc_pkg::CMD_CHECK: begin
        ck   = seg_kind(ax, ay, bx, by);
        stop = 1'b0;
        for (int i = 0; i < tab_count && !stop; i++) begin
          cx = tab_ax[i];
          cy = tab_ay[i];
          dx = tab_bx[i];
          dy = tab_by[i];
          if (segs_cross(ax, ay, bx, by, cx, cy, dx, dy)) begin
            same = (ax == cx && ay == cy && bx == dx && by == dy) ||
                   (ax == dx && ay == dy && bx == cx && by == cy);
            shared = (ax == cx && ay == cy) || (ax == dx && ay == dy) ||
                     (bx == cx && by == cy) || (bx == dx && by == dy);
            if (same || tab_hard[i]) begin
              r.violates = 1'b1;
              stop       = 1'b1;
            end else if (!shared) begin
              if (right_angle(ck, seg_kind(cx, cy, dx, dy))) begin
                if (r.legal < ssc_pkg::LEGAL_MAX) r.legal = r.legal + 7'd1;
              end else begin
                r.violates = 1'b1;
                stop       = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    pending = {pending, r};
  endfunction

  task check_result(logic v, logic [6:0] l, logic s);
    crossing_result_t e;
    if (pending.size() == 0) begin
      report($sformatf("result with nothing pending: violates=%0b legal=%0d status=%0b",
                       v, l, s));
      return;
    end
    e = pending.pop_front();
    if (v !== e.violates)
      report($sformatf("violates got %0b want %0b", v, e.violates));
    if (l !== e.legal)
      report($sformatf("legal_crossings got %0d want %0d", l, e.legal));
    if (s !== e.status)
      report($sformatf("status got %0b want %0b", s, e.status));
  endtask
endclass

module tb;
  localparam int          TABLE_DEPTH  = 64;
  localparam int          RANDOM_ITEMS = 1930;
  localparam int          HOLD_CYCLES  = 1500;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_start_x;
  logic signed [15:0] in_start_y;
  logic signed [15:0] in_end_x;
  logic signed [15:0] in_end_y;
  logic               in_hard_in;
  logic               out_valid;
  logic               out_stall;
  logic               out_violates;
  logic [6:0]         out_legal_crossings;
  logic               out_status;

  crossing_scoreboard sb = new();

  // stimulus-side copy of the stored segments, used to aim candidates
  logic [15:0] g_ax[TABLE_DEPTH];
  logic [15:0] g_ay[TABLE_DEPTH];
  logic [15:0] g_bx[TABLE_DEPTH];
  logic [15:0] g_by[TABLE_DEPTH];
  int          g_n;

  int          sent;
  int          burst_left;
  int          cycle_count;
  int          hold_asks;
  int          holds_done;

  logic [15:0] ax, ay, bx, by, ox, oy;
  logic        hrd;
  int          n_app, n_chk, pick, idx, j;
  bit          second_hold;

  int          st_mode, st_len, st_period, st_i;

  seed_segment_crossing_checker #(
    .MAX_SEGMENTS(TABLE_DEPTH),
    .COORD_BITS  (16)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_hard_in         (in_hard_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_violates       (out_violates),
    .out_legal_crossings(out_legal_crossings),
    .out_status         (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_violates, out_legal_crossings, out_status);
      if (in_valid && !in_stall)
        sb.note_item(in_cmd, in_start_x, in_start_y, in_end_x, in_end_y, in_hard_in);
    end
  end

  // receiver stall patterns, with a long hold-off whenever one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      st_mode   = $urandom_range(0, 3);
      st_len    = $urandom_range(20, 300);
      st_period = $urandom_range(2, 9);
      for (st_i = 0; st_i < st_len; st_i++) begin
        @(negedge clk);
        if (holds_done < hold_asks) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          holds_done++;
        end
        case (st_mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ((st_i % st_period) < (st_period / 2));
        endcase
      end
    end
  end

  function automatic logic [15:0] rnd16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic [15:0] near(logic [15:0] c);
    int off;
    off = $urandom_range(0, 12);
    return c + off[15:0] - 16'd6;
  endfunction

  // segment starting near an origin: horizontal, vertical, diagonal, skewed or wild
  function automatic void make_seg(input logic [15:0] px, input logic [15:0] py,
                                   output logic [15:0] sx, output logic [15:0] sy,
                                   output logic [15:0] ex, output logic [15:0] ey);
    int          k, n;
    logic [15:0] len;
    logic        neg;
    n   = $urandom_range(0, 8);
    len = n[15:0];
    neg = ($urandom_range(0, 1) == 1);
    k   = $urandom_range(0, 5);
    sx  = near(px);
    sy  = near(py);
    case (k)
      0: begin
        ex = neg ? sx - len : sx + len;
        ey = sy;
      end
      1: begin
        ex = sx;
        ey = neg ? sy - len : sy + len;
      end
      2: begin
        ex = neg ? sx - len : sx + len;
        ey = neg ? sy - len : sy + len;
      end
      3: begin
        ex = neg ? sx - len : sx + len;
        ey = neg ? sy + len : sy - len;
      end
      4: begin
        ex = near(px);
        ey = near(py);
      end
      default: begin
        ex = rnd16();
        ey = rnd16();
      end
    endcase
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [15:0] sx, input logic [15:0] sy,
                      input logic [15:0] ex, input logic [15:0] ey, input logic hard);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_cmd     = cmd;
    in_start_x = sx;
    in_start_y = sy;
    in_end_x   = ex;
    in_end_y   = ey;
    in_hard_in = hard;
    in_valid   = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == ssc_pkg::CMD_CLEAR) begin
      g_n = 0;
    end else if (cmd == ssc_pkg::CMD_APPEND && g_n < TABLE_DEPTH) begin
      g_ax[g_n] = sx;
      g_ay[g_n] = sy;
      g_bx[g_n] = ex;
      g_by[g_n] = ey;
      g_n++;
    end
    if (cmd != CMD_UNUSED) sent++;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = ssc_pkg::CMD_CLEAR;
    in_start_x  = '0;
    in_start_y  = '0;
    in_end_x    = '0;
    in_end_y    = '0;
    in_hard_in  = 1'b0;
    g_n         = 0;
    sent        = 0;
    burst_left  = 0;
    cycle_count = 0;
    hold_asks   = 0;
    holds_done  = 0;
    second_hold = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, unused command, each rule of the walk, extreme coordinates
    send(ssc_pkg::CMD_CHECK, 16'd0, 16'd0, 16'd5, 16'd0, 1'b1);
    send(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send(ssc_pkg::CMD_APPEND, 16'd0, 16'd0, 16'd10, 16'd0, 1'b0);
    send(ssc_pkg::CMD_APPEND, 16'd20, -16'sd5, 16'd20, 16'd5, 1'b1);
    send(ssc_pkg::CMD_APPEND, 16'd30, 16'd0, 16'd36, 16'd6, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd5, -16'sd3, 16'd5, 16'd3, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd0, 16'd0, 16'd10, 16'd0, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd10, 16'd0, 16'd0, 16'd0, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd15, 16'd0, 16'd25, 16'd0, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd10, 16'd0, 16'd10, 16'd8, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd31, 16'd5, 16'd35, 16'd1, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd2, -16'sd2, 16'd4, 16'd3, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd5, 16'd0, 16'd15, 16'd0, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd5, 16'd0, 16'd5, 16'd4, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'd3, 16'd0, 16'd3, 16'd0, 1'b0);
    send(ssc_pkg::CMD_CLEAR, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send(ssc_pkg::CMD_APPEND, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
    send(ssc_pkg::CMD_APPEND, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    send(ssc_pkg::CMD_CLEAR, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send(ssc_pkg::CMD_CHECK, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1);

    // random: episodes of clear, a run of appends, then aimed checks
    sent = 0;
    hold_asks++;
    while (sent < RANDOM_ITEMS) begin
      if (!second_hold && sent >= RANDOM_ITEMS / 2) begin
        hold_asks++;
        second_hold = 1'b1;
      end
      if ($urandom_range(0, 4) != 0)
        send(ssc_pkg::CMD_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(),
             ($urandom_range(0, 1) == 1));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        idx = $urandom_range(0, 2000) - 1000;
        ox  = idx[15:0];
        idx = $urandom_range(0, 2000) - 1000;
        oy  = idx[15:0];
      end else if (pick < 9) begin
        ox = ($urandom_range(0, 1) == 1) ? 16'h7FFC : 16'h8003;
        oy = ($urandom_range(0, 1) == 1) ? 16'h7FFC : 16'h8003;
      end else begin
        ox = rnd16();
        oy = rnd16();
      end
      pick  = $urandom_range(0, 9);
      n_app = (pick < 6) ? $urandom_range(0, 10) :
              (pick < 9) ? $urandom_range(11, 40) : $urandom_range(60, 70);
      for (j = 0; j < n_app; j++) begin
        make_seg(ox, oy, ax, ay, bx, by);
        hrd = ($urandom_range(0, 5) == 0);
        send(ssc_pkg::CMD_APPEND, ax, ay, bx, by, hrd);
        if ($urandom_range(0, 29) == 0)
          send(CMD_UNUSED, rnd16(), rnd16(), rnd16(), rnd16(), ($urandom_range(0, 1) == 1));
      end
      n_chk = $urandom_range(1, 8);
      for (j = 0; j < n_chk; j++) begin
        pick = $urandom_range(0, 9);
        make_seg(ox, oy, ax, ay, bx, by);
        if (g_n > 0 && pick < 3) begin
          idx = $urandom_range(0, g_n - 1);
          if (pick == 0) begin
            ax = g_ax[idx];
            ay = g_ay[idx];
            bx = g_bx[idx];
            by = g_by[idx];
          end else if (pick == 1) begin
            ax = g_bx[idx];
            ay = g_by[idx];
            bx = g_ax[idx];
            by = g_ay[idx];
          end else begin
            // start on a stored endpoint so the shared-endpoint skip gets hit
            make_seg(g_bx[idx], g_by[idx], ax, ay, bx, by);
            ax = g_bx[idx];
            ay = g_by[idx];
          end
        end else if (pick == 3) begin
          ax = rnd16();
          ay = rnd16();
          bx = rnd16();
          by = rnd16();
        end
        hrd = ($urandom_range(0, 1) == 1);
        send(ssc_pkg::CMD_CHECK, ax, ay, bx, by, hrd);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/ssc_pkg.sv
src/ssc_front.sv
src/ssc_fifo.sv
src/ssc_back.sv
src/seed_segment_crossing_checker.sv
bench/tb.sv
